>>> hw/rtl/hsv_to_rgb_converter_macros.svh
// Assertion macros for the color converter.
// Both expect signals named clock and reset in the scope of use.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define HSVRGB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define HSVRGB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define HSVRGB_ASSERT_NOW(lbl, ante, cons, msg)

`define HSVRGB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hw/rtl/hsvrgb_pkg.sv
`timescale 1ns / 1ps

package hsvrgb_pkg;

   localparam int unsigned MAX_LEVEL  = 1000;
   localparam int unsigned LEVEL_W    = 10;
   localparam int unsigned HUE_W      = 9;
   localparam int unsigned SECTOR_DEG = 60;
   localparam int unsigned F_W        = $clog2(SECTOR_DEG);
   localparam int unsigned RAW_SEC    = ((1 << HUE_W) - 1) / SECTOR_DEG;
   localparam int unsigned RAW_SEC_W  = $clog2(RAW_SEC + 1);

   // Common denominator: p, q and t are all v * x / SCALE.
   localparam int unsigned SCALE  = MAX_LEVEL * SECTOR_DEG;
   localparam int unsigned X_W    = $clog2(SCALE + 1);
   localparam int unsigned PROD_W = LEVEL_W + X_W;

   // Exact floor division by SCALE for any PROD_W-bit numerator:
   // multiply by ceil(2^SHIFT / SCALE), error term stays below 2^X_W.
   localparam int unsigned   RECIP_SHIFT = PROD_W + X_W;
   localparam int unsigned   RECIP_W     = PROD_W + 2;
   localparam longint unsigned RECIP_MUL =
      ((64'd1 << RECIP_SHIFT) + SCALE - 1) / SCALE;

   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW   = 3'd0,
      SECTOR_YELLOW_GREEN = 3'd1,
      SECTOR_GREEN_CYAN   = 3'd2,
      SECTOR_CYAN_BLUE    = 3'd3,
      SECTOR_BLUE_MAGENTA = 3'd4,
      SECTOR_MAGENTA_RED  = 3'd5
   } sector_type;

   typedef struct packed {
      sector_type       sector;
      logic [F_W-1:0]   frac;
   } hue_split_type;

   function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] x);
      logic [LEVEL_W-1:0] lim;
      lim = LEVEL_W'(MAX_LEVEL);
      return (x > lim) ? lim : x;
   endfunction

   // Sector is hue / 60, saturated at the last sector; frac is hue mod 60.
   function automatic hue_split_type split_hue(input logic [HUE_W-1:0] hue);
      hue_split_type         res;
      logic [RAW_SEC_W-1:0]  cnt;
      logic [HUE_W-1:0]      base;
      cnt = '0;
      for (int k = 1; k <= RAW_SEC; k++) begin
         if (hue >= HUE_W'(k * SECTOR_DEG)) cnt = RAW_SEC_W'(k);
      end
      base = HUE_W'(HUE_W'(cnt) * HUE_W'(SECTOR_DEG));
      res.frac = F_W'(hue - base);
      if (cnt >= RAW_SEC_W'(SECTOR_MAGENTA_RED)) res.sector = SECTOR_MAGENTA_RED;
      else res.sector = sector_type'(cnt[2:0]);
      return res;
   endfunction

   function automatic logic [LEVEL_W-1:0] div_scale(input logic [PROD_W-1:0] n);
      logic [PROD_W+RECIP_W-1:0] prod;
      prod = (PROD_W+RECIP_W)'(n) * (PROD_W+RECIP_W)'(RECIP_MUL);
      return prod[RECIP_SHIFT +: LEVEL_W];
   endfunction

endpackage

>>> hw/rtl/hsv_to_rgb_converter.sv
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  req_hue, req_saturation, req_brightness
//  rsp      out        rsp_valid/rsp_ready  rsp_red_level, rsp_green_level, rsp_blue_level
//
//  Five register stages: hue split, weight terms, v * weight, divide by
//  60 * MAX_LEVEL, sector select into the output register.
//  One item per cycle while the output is not stalled.
//  Each stage has its own valid bit and fills bubbles while later stages stall.
//  Reset clears the valid bits only; no pass is needed after reset.
`timescale 1ns / 1ps
`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter
   import hsvrgb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [HUE_W-1:0]   req_hue,
   input  logic [LEVEL_W-1:0] req_saturation,
   input  logic [LEVEL_W-1:0] req_brightness,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [LEVEL_W-1:0] rsp_red_level,
   output logic [LEVEL_W-1:0] rsp_green_level,
   output logic [LEVEL_W-1:0] rsp_blue_level
);

   // stage ready chain
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   // stage 1: clamp, grey flag, hue split
   logic               vld1_ff;
   logic               grey1_ff, grey1_in;
   sector_type         sec1_ff;
   logic [F_W-1:0]     frac1_ff;
   logic [LEVEL_W-1:0] sat1_ff, sat1_in;
   logic [LEVEL_W-1:0] val1_ff, val1_in;
   hue_split_type      split1_in;

   // stage 2: weights x = SCALE - s * (60, f, 60 - f)
   logic               vld2_ff;
   logic               grey2_ff;
   sector_type         sec2_ff;
   logic [LEVEL_W-1:0] val2_ff;
   logic [X_W-1:0]     xp2_ff, xp2_in, xq2_ff, xq2_in, xt2_ff, xt2_in;

   // stage 3: products
   logic               vld3_ff;
   logic               grey3_ff;
   sector_type         sec3_ff;
   logic [LEVEL_W-1:0] val3_ff;
   logic [PROD_W-1:0]  np3_ff, np3_in, nq3_ff, nq3_in, nt3_ff, nt3_in;

   // stage 4: quotients
   logic               vld4_ff;
   logic               grey4_ff;
   sector_type         sec4_ff;
   logic [LEVEL_W-1:0] val4_ff;
   logic [LEVEL_W-1:0] p4_ff, p4_in, q4_ff, q4_in, t4_ff, t4_in;

   // output register
   logic               vld5_ff;
   logic [LEVEL_W-1:0] red5_ff, red5_in, grn5_ff, grn5_in, blu5_ff, blu5_in;

   assign rdy5      = !vld5_ff || rsp_ready;
   assign rdy4      = !vld4_ff || rdy5;
   assign rdy3      = !vld3_ff || rdy4;
   assign rdy2      = !vld2_ff || rdy3;
   assign rdy1      = !vld1_ff || rdy2;
   assign req_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else begin
         if (rdy1) vld1_ff <= req_valid;
         if (rdy2) vld2_ff <= vld1_ff;
         if (rdy3) vld3_ff <= vld2_ff;
         if (rdy4) vld4_ff <= vld3_ff;
         if (rdy5) vld5_ff <= vld4_ff;
      end
   end

   // stage 1
   always_comb begin
      sat1_in   = clamp_level(req_saturation);
      val1_in   = clamp_level(req_brightness);
      grey1_in  = (sat1_in == '0);
      split1_in = split_hue(req_hue);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         grey1_ff <= grey1_in;
         sec1_ff  <= split1_in.sector;
         frac1_ff <= split1_in.frac;
         sat1_ff  <= sat1_in;
         val1_ff  <= val1_in;
      end
   end

   // stage 2
   always_comb begin
      xp2_in = X_W'(SCALE) - X_W'(X_W'(sat1_ff) * X_W'(SECTOR_DEG));
      xq2_in = X_W'(SCALE) - X_W'(X_W'(sat1_ff) * X_W'(frac1_ff));
      xt2_in = X_W'(SCALE)
             - X_W'(X_W'(sat1_ff) * X_W'(F_W'(SECTOR_DEG) - frac1_ff));
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         grey2_ff <= grey1_ff;
         sec2_ff  <= sec1_ff;
         val2_ff  <= val1_ff;
         xp2_ff   <= xp2_in;
         xq2_ff   <= xq2_in;
         xt2_ff   <= xt2_in;
      end
   end

   // stage 3
   always_comb begin
      np3_in = PROD_W'(val2_ff) * PROD_W'(xp2_ff);
      nq3_in = PROD_W'(val2_ff) * PROD_W'(xq2_ff);
      nt3_in = PROD_W'(val2_ff) * PROD_W'(xt2_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         grey3_ff <= grey2_ff;
         sec3_ff  <= sec2_ff;
         val3_ff  <= val2_ff;
         np3_ff   <= np3_in;
         nq3_ff   <= nq3_in;
         nt3_ff   <= nt3_in;
      end
   end

   // stage 4
   always_comb begin
      p4_in = div_scale(np3_ff);
      q4_in = div_scale(nq3_ff);
      t4_in = div_scale(nt3_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         grey4_ff <= grey3_ff;
         sec4_ff  <= sec3_ff;
         val4_ff  <= val3_ff;
         p4_ff    <= p4_in;
         q4_ff    <= q4_in;
         t4_ff    <= t4_in;
      end
   end

   // stage 5: sector select
   always_comb begin
      if (grey4_ff) begin
         red5_in = val4_ff;
         grn5_in = val4_ff;
         blu5_in = val4_ff;
      end else begin
         unique case (sec4_ff)
            SECTOR_RED_YELLOW: begin
               red5_in = val4_ff; grn5_in = t4_ff;   blu5_in = p4_ff;
            end
            SECTOR_YELLOW_GREEN: begin
               red5_in = q4_ff;   grn5_in = val4_ff; blu5_in = p4_ff;
            end
            SECTOR_GREEN_CYAN: begin
               red5_in = p4_ff;   grn5_in = val4_ff; blu5_in = t4_ff;
            end
            SECTOR_CYAN_BLUE: begin
               red5_in = p4_ff;   grn5_in = q4_ff;   blu5_in = val4_ff;
            end
            SECTOR_BLUE_MAGENTA: begin
               red5_in = t4_ff;   grn5_in = p4_ff;   blu5_in = val4_ff;
            end
            default: begin
               red5_in = val4_ff; grn5_in = p4_ff;   blu5_in = q4_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         red5_ff <= red5_in;
         grn5_ff <= grn5_in;
         blu5_ff <= blu5_in;
      end
   end

   assign rsp_valid       = vld5_ff;
   assign rsp_red_level   = red5_ff;
   assign rsp_green_level = grn5_ff;
   assign rsp_blue_level  = blu5_ff;

   `HSVRGB_ASSERT_NEXT(a_accept_fills_s1, req_valid && req_ready, vld1_ff, "accepted item not in stage 1")
   `HSVRGB_ASSERT_NEXT(a_s4_held_on_stall, vld4_ff && !rdy5, vld4_ff && $stable(p4_ff), "stage 4 item lost on stall")
   `HSVRGB_ASSERT_NOW(a_quot_le_value, vld4_ff, p4_ff <= val4_ff && q4_ff <= val4_ff && t4_ff <= val4_ff, "quotient above value")
   `HSVRGB_ASSERT_NOW(a_level_in_range, rsp_valid, rsp_red_level <= LEVEL_W'(MAX_LEVEL) && rsp_green_level <= LEVEL_W'(MAX_LEVEL) && rsp_blue_level <= LEVEL_W'(MAX_LEVEL), "level above full scale")

endmodule
